FILE: sv/aml_s5_sleep_type_scanner_top_macros.svh
// assertion macros for the _S5_ sleep-type scanner
// depends on: a clock named aclk and an active-low reset named aresetn in the user
`ifndef AML_S5_SLEEP_TYPE_SCANNER_TOP_MACROS_SVH
`define AML_S5_SLEEP_TYPE_SCANNER_TOP_MACROS_SVH

// same-cycle implication
`define S5_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define S5_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/s5scan_pkg.sv
// shared types, constants and decode helpers for the _S5_ scanner
// no dependencies
package s5scan_pkg;

    localparam int unsigned DEF_CANDIDATE_TRACKERS = 10;

    // aml opcodes and name characters
    localparam logic [7:0] OP_NAME     = 8'h08;
    localparam logic [7:0] OP_ROOT     = 8'h5C;
    localparam logic [7:0] OP_PACKAGE  = 8'h12;
    localparam logic [7:0] OP_ZERO     = 8'h00;
    localparam logic [7:0] OP_ONE      = 8'h01;
    localparam logic [7:0] OP_BYTE     = 8'h0A;
    localparam logic [7:0] OP_WORD     = 8'h0B;
    localparam logic [7:0] OP_DWORD    = 8'h0C;
    localparam logic [7:0] OP_QWORD    = 8'h0E;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_S        = 8'h53;
    localparam logic [7:0] CH_5        = 8'h35;

    localparam int unsigned SLP_SHIFT  = 10;
    localparam int unsigned SLP_W      = 13;
    localparam logic [3:0]  SEEN_MIN   = 4'd8;

    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_PKGOP  = 11'b000_0000_0010,
        PH_LEAD   = 11'b000_0000_0100,
        PH_FOLLOW = 11'b000_0000_1000,
        PH_COUNT  = 11'b000_0001_0000,
        PH_OPA    = 11'b000_0010_0000,
        PH_AFIRST = 11'b000_0100_0000,
        PH_AREST  = 11'b000_1000_0000,
        PH_OPB    = 11'b001_0000_0000,
        PH_BFIRST = 11'b010_0000_0000,
        PH_BREST  = 11'b100_0000_0000
    } phase_t;

    // one candidate: phase, bytes still to skip, a in 2:0 and b in 5:3
    typedef struct packed {
        phase_t     phase;
        logic [3:0] left;
        logic [5:0] vals;
    } trk_t;

    // a chosen result travelling toward the newest cell
    typedef struct packed {
        logic       hit;
        logic [2:0] a;
        logic [2:0] b;
    } pick_t;

    // older-to-newer sweep: completed winner and truncated winner
    typedef struct packed {
        pick_t win;
        pick_t trunc;
    } sweep_t;

    // newer-to-older shift path: all cells so far occupied, and the word to shift
    typedef struct packed {
        logic full;
        trk_t trk;
    } fwd_t;

    localparam trk_t TRK_IDLE  = '{phase: PH_IDLE,  left: 4'd0, vals: 6'd0};
    localparam trk_t TRK_FRESH = '{phase: PH_PKGOP, left: 4'd0, vals: 6'd0};

    // data bytes after an integer prefix, zero for a bad prefix
    function automatic logic [3:0] int_len(input logic [7:0] op);
        logic [3:0] n;
        case (op)
            OP_BYTE:  n = 4'd1;
            OP_WORD:  n = 4'd2;
            OP_DWORD: n = 4'd4;
            OP_QWORD: n = 4'd8;
            default:  n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: sv/s5scan_cell.sv
// one candidate tracker cell of the _S5_ scanner chain
// depends on: s5scan_pkg
module s5scan_cell
    import s5scan_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       clear,
    input  logic       launch,
    input  logic [7:0] data_byte,
    input  fwd_t       fwd_in,
    output fwd_t       fwd_out,
    input  sweep_t     sweep_in,
    output sweep_t     sweep_out,
    output trk_t       cur
);

    trk_t       trk_reg;
    trk_t       trk_next;
    trk_t       adv;
    trk_t       surv;
    logic       done;
    logic       dead;
    logic       survive;
    logic [2:0] bres;
    logic [2:0] a_cur;
    logic [3:0] n_len;
    logic [3:0] left_dec;

    assign a_cur    = trk_reg.vals[2:0];
    assign n_len    = int_len(data_byte);
    assign left_dec = trk_reg.left - 4'd1;

    // advance by one byte
    always_comb begin
        adv  = trk_reg;
        done = 1'b0;
        dead = 1'b0;
        bres = 3'd0;
        unique case (trk_reg.phase)
            PH_IDLE: begin
                dead = 1'b1;
            end
            PH_PKGOP: begin
                if (data_byte != OP_PACKAGE) begin
                    dead = 1'b1;
                end else begin
                    adv.phase = PH_LEAD;
                end
            end
            PH_LEAD: begin
                adv.left  = {2'b00, data_byte[7:6]};
                adv.phase = (data_byte[7:6] != 2'b00) ? PH_FOLLOW : PH_COUNT;
            end
            PH_FOLLOW: begin
                adv.left = left_dec;
                if (left_dec == 4'd0) begin
                    adv.phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                adv.phase = PH_OPA;
            end
            PH_OPA: begin
                if (data_byte == OP_ZERO || data_byte == OP_ONE) begin
                    adv.vals  = {5'd0, data_byte[0]};
                    adv.phase = PH_OPB;
                end else if (n_len == 4'd0) begin
                    dead = 1'b1;
                end else begin
                    adv.left  = n_len;
                    adv.phase = PH_AFIRST;
                end
            end
            PH_AFIRST: begin
                adv.vals  = {3'd0, data_byte[2:0]};
                adv.left  = left_dec;
                adv.phase = (left_dec != 4'd0) ? PH_AREST : PH_OPB;
            end
            PH_AREST: begin
                adv.left  = left_dec;
                adv.phase = (left_dec != 4'd0) ? PH_AREST : PH_OPB;
            end
            PH_OPB: begin
                if (data_byte == OP_ZERO || data_byte == OP_ONE) begin
                    done = 1'b1;
                    bres = data_byte[2:0];
                end else if (n_len == 4'd0) begin
                    done = 1'b1;
                    bres = a_cur;
                end else begin
                    adv.left  = n_len;
                    adv.phase = PH_BFIRST;
                end
            end
            PH_BFIRST: begin
                adv.vals = {data_byte[2:0], a_cur};
                adv.left = left_dec;
                if (left_dec == 4'd0) begin
                    done = 1'b1;
                    bres = data_byte[2:0];
                end else begin
                    adv.phase = PH_BREST;
                end
            end
            PH_BREST: begin
                adv.left = left_dec;
                if (left_dec == 4'd0) begin
                    done = 1'b1;
                    bres = trk_reg.vals[5:3];
                end
            end
            default: begin
                dead = 1'b1;
            end
        endcase
    end

    // an older winner drops this cell
    assign survive = !dead && !done && !sweep_in.win.hit;
    assign surv    = survive ? adv : TRK_IDLE;

    always_comb begin
        sweep_out = sweep_in;
        if (!sweep_in.win.hit && done) begin
            sweep_out.win = '{hit: 1'b1, a: adv.vals[2:0], b: bres};
        end
        if (!sweep_in.trunc.hit && survive &&
            (adv.phase == PH_OPB || adv.phase == PH_BFIRST || adv.phase == PH_BREST)) begin
            sweep_out.trunc = '{hit: 1'b1, a: adv.vals[2:0], b: adv.vals[2:0]};
        end
    end

    assign fwd_out.full = fwd_in.full && survive;
    assign fwd_out.trk  = surv;

    always_comb begin
        if (clear) begin
            trk_next = TRK_IDLE;
        end else if (launch && fwd_in.full) begin
            trk_next = fwd_in.trk;
        end else begin
            trk_next = surv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trk_reg <= TRK_IDLE;
        end else if (step) begin
            trk_reg <= trk_next;
        end
    end

    assign cur = trk_reg;

endmodule

FILE: sv/aml_s5_sleep_type_scanner_top.sv
// top level of the _S5_ sleep-type scanner: history, tracker chain, latch, result register
// depends on: s5scan_pkg, s5scan_cell, aml_s5_sleep_type_scanner_top_macros.svh
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  s_      | in  | s_valid / s_ready   | s_data_byte[7:0], s_last_byte
//  m_      | out | m_valid / m_ready   | m_found, m_sleep_type_a[12:0], m_sleep_type_b[12:0]
//
// one byte per cycle while s_ready is high; the whole chain of cells updates in the cycle a word is taken
// the per-byte path is the ripple through all tracker cells (winner sweep and shift chain)
// a word with s_last_byte loads one result word into the output register
// s_ready drops only while a result sits unclaimed in the output register
// reset is synchronous and active low; no clearing pass is needed
`include "aml_s5_sleep_type_scanner_top_macros.svh"

module aml_s5_sleep_type_scanner_top
    import s5scan_pkg::*;
#(
    parameter int unsigned CANDIDATE_TRACKERS = DEF_CANDIDATE_TRACKERS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_last_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [SLP_W-1:0]    m_sleep_type_a,
    output logic [SLP_W-1:0]    m_sleep_type_b
);

    // the previous five bytes, entry 0 newest
    logic [4:0][7:0] hist_reg;
    logic [3:0]      seen_reg;

    // best completed match so far
    logic            latch_found_reg;
    logic [2:0]      latch_a_reg;
    logic [2:0]      latch_b_reg;
    logic            latch_found_next;
    logic [2:0]      latch_a_next;
    logic [2:0]      latch_b_next;

    // result register
    logic            m_valid_reg;
    logic            m_found_reg;
    logic [2:0]      m_a_reg;
    logic [2:0]      m_b_reg;
    logic            res_found;
    logic [2:0]      res_a;
    logic [2:0]      res_b;

    logic            step;
    logic            clear;
    logic            name_hit;
    logic            launch;

    // chain wiring: fwd runs newest to oldest, sweep runs oldest to newest
    fwd_t            fwd   [CANDIDATE_TRACKERS+1];
    sweep_t          sweep [CANDIDATE_TRACKERS+1];
    trk_t            cell_cur [CANDIDATE_TRACKERS];
    logic [CANDIDATE_TRACKERS-1:0] win_vec;
    logic [CANDIDATE_TRACKERS-1:0] idle_vec;

    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;
    assign clear   = s_last_byte;

    // the newest end of the chain offers a fresh candidate
    assign fwd[0]                  = '{full: 1'b1, trk: TRK_FRESH};
    assign sweep[CANDIDATE_TRACKERS] = '0;

    for (genvar k = 0; k < CANDIDATE_TRACKERS; k++) begin : g_cell
        s5scan_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (step),
            .clear     (clear),
            .launch    (launch),
            .data_byte (s_data_byte),
            .fwd_in    (fwd[k]),
            .fwd_out   (fwd[k+1]),
            .sweep_in  (sweep[k+1]),
            .sweep_out (sweep[k]),
            .cur       (cell_cur[k])
        );
        assign win_vec[k]  = sweep[k].win.hit && !sweep[k+1].win.hit;
        assign idle_vec[k] = (cell_cur[k].phase == PH_IDLE);
    end

    // the oldest completed candidate replaces the latch
    always_comb begin
        latch_found_next = latch_found_reg;
        latch_a_next     = latch_a_reg;
        latch_b_next     = latch_b_reg;
        if (sweep[0].win.hit) begin
            latch_found_next = 1'b1;
            latch_a_next     = sweep[0].win.a;
            latch_b_next     = sweep[0].win.b;
        end
    end

    // name match: "_S5_" after 0x08, or after 0x08 and a backslash
    always_comb begin
        name_hit = 1'b0;
        if (s_data_byte == CH_UNDER && hist_reg[0] == CH_5 && hist_reg[1] == CH_S &&
            hist_reg[2] == CH_UNDER) begin
            name_hit = (seen_reg >= 4'd4 && hist_reg[3] == OP_NAME) ||
                       (seen_reg >= 4'd5 && hist_reg[4] == OP_NAME && hist_reg[3] == OP_ROOT);
        end
    end

    // new candidate only with a free cell and nothing latched
    assign launch = name_hit && !latch_found_next && !fwd[CANDIDATE_TRACKERS].full;

    // end of body: a candidate holding a but not b wins over the latch
    always_comb begin
        res_found = latch_found_next;
        res_a     = latch_a_next;
        res_b     = latch_b_next;
        if (sweep[0].trunc.hit) begin
            res_found = 1'b1;
            res_a     = sweep[0].trunc.a;
            res_b     = sweep[0].trunc.b;
        end
        // short body never reports a match
        if ((seen_reg + 4'd1) < SEEN_MIN) begin
            res_found = 1'b0;
        end
        if (!res_found) begin
            res_a = 3'd0;
            res_b = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg        <= '0;
            seen_reg        <= 4'd0;
            latch_found_reg <= 1'b0;
            latch_a_reg     <= 3'd0;
            latch_b_reg     <= 3'd0;
        end else if (step) begin
            if (clear) begin
                hist_reg        <= '0;
                seen_reg        <= 4'd0;
                latch_found_reg <= 1'b0;
                latch_a_reg     <= 3'd0;
                latch_b_reg     <= 3'd0;
            end else begin
                hist_reg        <= {hist_reg[3:0], s_data_byte};
                seen_reg        <= (seen_reg < SEEN_MIN) ? seen_reg + 4'd1 : seen_reg;
                latch_found_reg <= latch_found_next;
                latch_a_reg     <= latch_a_next;
                latch_b_reg     <= latch_b_next;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && s_last_byte) begin
            m_found_reg <= res_found;
            m_a_reg     <= res_a;
            m_b_reg     <= res_b;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_sleep_type_a = {m_a_reg, SLP_SHIFT'(0)};
    assign m_sleep_type_b = {m_b_reg, SLP_SHIFT'(0)};

    // at most one cell completes as the winner in a byte
    `S5_ASSERT_IMP(a_one_winner, step, $onehot0(win_vec), "more than one winning cell")

    // the chain is empty after the last byte of a body
    `S5_ASSERT_NXT(a_clear_after_last, step && s_last_byte, &idle_vec, "cells busy after last byte")

    // a latched match stays latched within a body
    `S5_ASSERT_NXT(a_latch_holds, step && !s_last_byte && latch_found_reg, latch_found_reg,
        "latched match lost")

    // a body shorter than eight bytes reports no match
    `S5_ASSERT_NXT(a_short_body, step && s_last_byte && seen_reg < 4'd7, !m_found_reg,
        "match reported for short body")

endmodule
